FILE: hw/rtl/kalman_rate_estimator_core_macros.svh
// Assertion macros shared by the rate estimator RTL.
// Depends on nothing; included by the top level only.
`ifndef KALMAN_RATE_ESTIMATOR_CORE_MACROS_SVH
`define KALMAN_RATE_ESTIMATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KRE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define KRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/kre_pkg.sv
// Shared widths, codes and defaults of the Kalman rate estimator.
// No dependencies; used by kre_mul and kalman_rate_estimator_core.
package kre_pkg;

	localparam int MODE_W    = 1;
	localparam int BYTES_W   = 24;
	localparam int TIME_W    = 48;
	localparam int RATE_W    = 40;
	localparam int VAR_W     = 34;
	localparam int NOISE_W   = 34;
	localparam int ACC_W     = 32;
	localparam int PM_W      = 35;
	localparam int DEN_W     = 36;

	// bytes * 8 * 1e6 in one multiply by a 23-bit constant
	localparam int SCALE_W = 24;
	localparam logic [SCALE_W-1:0] BIT_RATE_SCALE = 24'd8000000;
	localparam int NUM_W = ACC_W + 23;

	localparam int MUL_DIGIT_W = 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 34;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'd1;

	localparam logic [MODE_W-1:0] MODE_ADD_BYTES = 1'b0;
	localparam logic [MODE_W-1:0] MODE_UPDATE    = 1'b1;

	localparam int FRACTION_BITS_DEF = 32;
	localparam logic [RATE_W-1:0] INITIAL_RATE_DEF = 40'd1000000;

endpackage

FILE: hw/rtl/kre_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; instantiated by kalman_rate_estimator_core.
module kre_div #(
	parameter int N_W = 67,
	parameter int D_W = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic [N_W-1:0] quotient,
	output logic           done
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   nq_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             ge;

	// The dividend leaves nq_q at the top while quotient bits enter at the bottom.
	assign trial = {rem_q, nq_q[N_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(N_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			nq_q  <= {nq_q[N_W-2:0], ge};
		end
	end

	assign quotient = nq_q;
	assign done     = done_q;

endmodule

FILE: hw/rtl/kre_mul.sv
// Digit-serial multiplier, one 8-bit digit of the second operand per cycle.
// Depends on kre_pkg; instantiated by kalman_rate_estimator_core.
module kre_mul #(
	parameter int A_W = 40,
	parameter int B_W = 33
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic [A_W+((B_W+kre_pkg::MUL_DIGIT_W-1)/kre_pkg::MUL_DIGIT_W)*
		kre_pkg::MUL_DIGIT_W-1:0] product,
	output logic     done
);

	localparam int DG_W  = kre_pkg::MUL_DIGIT_W;
	localparam int ND    = (B_W + DG_W - 1) / DG_W;
	localparam int BP_W  = ND * DG_W;
	localparam int P_W   = A_W + BP_W;
	localparam int CNT_W = $clog2(ND + 1);

	logic [A_W-1:0]      a_q;
	logic [BP_W-1:0]     b_q;
	logic [P_W-1:0]      prod_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                run_q;
	logic                done_q;
	logic [DG_W-1:0]     digit;
	logic [A_W+DG_W-1:0] pp;

	// Most significant digit first, so the running sum shifts left each step.
	assign digit = b_q[BP_W-1 -: DG_W];
	assign pp    = a_q * digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(ND);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= BP_W'(b);
			prod_q <= '0;
		end else if (run_q) begin
			b_q    <= {b_q[BP_W-DG_W-1:0], {DG_W{1'b0}}};
			prod_q <= {prod_q[P_W-DG_W-1:0], {DG_W{1'b0}}} + P_W'(pp);
		end
	end

	assign product = prod_q;
	assign done    = done_q;

endmodule

FILE: hw/rtl/kalman_rate_estimator_core.sv
// Sequence: a byte beat or a rate beat without elapsed time goes to ST_OUT, which raises
// out_valid once the output is free; a rate update runs a multiply, two divides on the
// bit-serial divider, two more multiplies, and then ST_OUT.
// Throughput: one beat at a time; input stall stays high until the result is registered.
// Reset: arst_n clears accumulator and time, loads initial rate, unit variance, default noise.
`include "kalman_rate_estimator_core_macros.svh"
module kalman_rate_estimator_core #(
	parameter int FRACTION_BITS = kre_pkg::FRACTION_BITS_DEF,
	parameter logic [kre_pkg::RATE_W-1:0] INITIAL_RATE = kre_pkg::INITIAL_RATE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [kre_pkg::MODE_W-1:0]  mode,
	input  logic [kre_pkg::BYTES_W-1:0] byte_count,
	input  logic [kre_pkg::TIME_W-1:0]  now_time,
	output logic out_valid,
	input  logic out_stall,
	output logic [kre_pkg::RATE_W-1:0] estimated_rate,
	output logic [kre_pkg::RATE_W-1:0] measured_rate,
	output logic [kre_pkg::VAR_W-1:0]  error_variance,
	output logic updated,
	input  logic cfg_we,
	input  logic [kre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kre_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int FB      = FRACTION_BITS;
	localparam int RATE_W  = kre_pkg::RATE_W;
	localparam int VAR_W   = kre_pkg::VAR_W;
	localparam int NOISE_W = kre_pkg::NOISE_W;
	localparam int ACC_W   = kre_pkg::ACC_W;
	localparam int TIME_W  = kre_pkg::TIME_W;
	localparam int PM_W    = kre_pkg::PM_W;
	localparam int DEN_W   = kre_pkg::DEN_W;
	localparam int NUM_W   = kre_pkg::NUM_W;
	localparam int GAIN_W  = FB + 1;

	localparam int DIV_N_W = (NUM_W > PM_W + FB) ? NUM_W : PM_W + FB;
	localparam int DIV_D_W = TIME_W;
	localparam int MUL_A_W = RATE_W;
	localparam int MUL_B_W = (GAIN_W > kre_pkg::SCALE_W) ? GAIN_W : kre_pkg::SCALE_W;
	localparam int MUL_ND  = (MUL_B_W + kre_pkg::MUL_DIGIT_W - 1) / kre_pkg::MUL_DIGIT_W;
	localparam int MUL_P_W = MUL_A_W + MUL_ND * kre_pkg::MUL_DIGIT_W;

	localparam logic [63:0] ONE_FX64 = 64'd1 << FB;
	localparam logic [63:0] M34_64   = (64'd1 << VAR_W) - 64'd1;
	localparam logic [VAR_W-1:0] VAR_RESET =
		VAR_W'((ONE_FX64 > M34_64) ? M34_64 : ONE_FX64);
	localparam logic [NOISE_W-1:0] Q_RESET = NOISE_W'((ONE_FX64 + 64'd500000) / 64'd1000000);
	localparam logic [NOISE_W-1:0] R_RESET = NOISE_W'((ONE_FX64 + 64'd50) / 64'd100);
	localparam logic [GAIN_W-1:0]  ONE_FX  = {1'b1, {FB{1'b0}}};

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_MR_GO   = 4'd1;
	localparam logic [3:0] ST_MR_WAIT = 4'd2;
	localparam logic [3:0] ST_DR_GO   = 4'd3;
	localparam logic [3:0] ST_DR_WAIT = 4'd4;
	localparam logic [3:0] ST_DG_GO   = 4'd5;
	localparam logic [3:0] ST_DG_WAIT = 4'd6;
	localparam logic [3:0] ST_ME_GO   = 4'd7;
	localparam logic [3:0] ST_ME_WAIT = 4'd8;
	localparam logic [3:0] ST_MP_GO   = 4'd9;
	localparam logic [3:0] ST_MP_WAIT = 4'd10;
	localparam logic [3:0] ST_OUT     = 4'd11;

	logic [3:0]         state_q;
	logic [NOISE_W-1:0] q_noise_q;
	logic [NOISE_W-1:0] r_noise_q;
	logic [ACC_W-1:0]   acc_q;
	logic [TIME_W-1:0]  last_q;
	logic [RATE_W-1:0]  est_q;
	logic [VAR_W-1:0]   var_q;

	// per-update working registers
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [RATE_W-1:0]  meas_q;
	logic               upd_q;
	logic [PM_W-1:0]    pm_q;
	logic [DEN_W-1:0]   den_q;
	logic [GAIN_W-1:0]  gain_q;

	logic               out_valid_q;
	logic [RATE_W-1:0]  out_est_q;
	logic [RATE_W-1:0]  out_meas_q;
	logic [VAR_W-1:0]   out_var_q;
	logic               out_upd_q;

	logic               in_take;
	logic               out_free;
	logic [ACC_W:0]     acc_sum;
	logic               time_later;
	logic [PM_W-1:0]    pm_next;
	logic [DEN_W-1:0]   den_next;
	logic               meas_ge;
	logic [RATE_W-1:0]  rate_diff;
	logic [RATE_W-1:0]  delta;
	logic [PM_W-1:0]    p_new;

	logic               mul_start;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_prod;
	logic               mul_done;
	logic               div_start;
	logic [DIV_N_W-1:0] div_n;
	logic [DIV_D_W-1:0] div_d;
	logic [DIV_N_W-1:0] div_q;
	logic               div_done;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign acc_sum    = {1'b0, acc_q} + (ACC_W + 1)'(byte_count);
	assign time_later = now_time > last_q;
	assign pm_next    = {1'b0, var_q} + {1'b0, q_noise_q};
	assign den_next   = {1'b0, pm_next} + {{(DEN_W - NOISE_W){1'b0}}, r_noise_q};
	assign meas_ge    = meas_q >= est_q;
	assign rate_diff  = meas_ge ? (meas_q - est_q) : (est_q - meas_q);
	assign delta      = mul_prod[FB +: RATE_W];
	assign p_new      = mul_prod[FB +: PM_W];

	// Operand selection for the shared units.
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		case (state_q)
			ST_MR_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(acc_q);
				mul_b     = MUL_B_W'(kre_pkg::BIT_RATE_SCALE);
			end
			ST_ME_GO: begin
				mul_start = 1'b1;
				mul_a     = rate_diff;
				mul_b     = MUL_B_W'(gain_q);
			end
			ST_MP_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(pm_q);
				mul_b     = MUL_B_W'(ONE_FX - gain_q);
			end
			ST_DR_GO: begin
				div_start = 1'b1;
				div_n     = DIV_N_W'(mul_prod[NUM_W-1:0]);
				div_d     = elapsed_q;
			end
			ST_DG_GO: begin
				div_start = 1'b1;
				div_n     = DIV_N_W'({pm_q, {FB{1'b0}}});
				div_d     = DIV_D_W'(den_q);
			end
			default: begin
			end
		endcase
	end

	kre_mul #(
		.A_W (MUL_A_W),
		.B_W (MUL_B_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_prod),
		.done    (mul_done)
	);

	kre_div #(
		.N_W (DIV_N_W),
		.D_W (DIV_D_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.quotient (div_q),
		.done     (div_done)
	);

	// Sequencer and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			q_noise_q   <= Q_RESET;
			r_noise_q   <= R_RESET;
			acc_q       <= '0;
			last_q      <= '0;
			est_q       <= INITIAL_RATE;
			var_q       <= VAR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kre_pkg::REG_PROCESS_NOISE:     q_noise_q <= cfg_data;
					kre_pkg::REG_MEASUREMENT_NOISE: r_noise_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (mode == kre_pkg::MODE_ADD_BYTES) begin
							acc_q   <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
							state_q <= ST_OUT;
						end else if (time_later) begin
							state_q <= ST_MR_GO;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MR_GO:   state_q <= ST_MR_WAIT;
				ST_MR_WAIT: if (mul_done) state_q <= ST_DR_GO;
				ST_DR_GO:   state_q <= ST_DR_WAIT;
				ST_DR_WAIT: if (div_done) state_q <= ST_DG_GO;
				ST_DG_GO:   state_q <= ST_DG_WAIT;
				ST_DG_WAIT: if (div_done) state_q <= ST_ME_GO;
				ST_ME_GO:   state_q <= ST_ME_WAIT;
				ST_ME_WAIT: begin
					if (mul_done) begin
						est_q   <= meas_ge ? (est_q + delta) : (est_q - delta);
						state_q <= ST_MP_GO;
					end
				end
				ST_MP_GO:   state_q <= ST_MP_WAIT;
				ST_MP_WAIT: begin
					if (mul_done) begin
						var_q   <= p_new[PM_W-1] ? {VAR_W{1'b1}} : p_new[VAR_W-1:0];
						acc_q   <= '0;
						last_q  <= now_q;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working and result registers, no reset needed.
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_q     <= now_time;
			elapsed_q <= now_time - last_q;
			meas_q    <= '0;
			upd_q     <= (mode == kre_pkg::MODE_UPDATE) && time_later;
		end
		if (state_q == ST_DR_WAIT && div_done) begin
			meas_q <= (|div_q[DIV_N_W-1:RATE_W]) ? {RATE_W{1'b1}} : div_q[RATE_W-1:0];
			pm_q   <= pm_next;
			den_q  <= den_next;
		end
		if (state_q == ST_DG_WAIT && div_done) begin
			// A zero denominator, from zero variance and both noise terms at zero, gives a zero gain.
			gain_q <= (den_q == '0) ? '0 : div_q[GAIN_W-1:0];
		end
		if (state_q == ST_OUT && out_free) begin
			out_est_q  <= est_q;
			out_meas_q <= meas_q;
			out_var_q  <= var_q;
			out_upd_q  <= upd_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign estimated_rate = out_est_q;
	assign measured_rate  = out_meas_q;
	assign error_variance = out_var_q;
	assign updated        = out_upd_q;

	`KRE_ASSERT_NOW(a_no_update_no_rate, clk, arst_n, out_valid && !updated, measured_rate == '0, "beat without update carries a measured rate")
	`KRE_ASSERT_NOW(a_gain_le_one, clk, arst_n, state_q == ST_ME_GO, gain_q <= ONE_FX, "Kalman gain above one")
	`KRE_ASSERT_NOW(a_mul_done_owned, clk, arst_n, mul_done, state_q == ST_MR_WAIT || state_q == ST_ME_WAIT || state_q == ST_MP_WAIT, "multiplier finished outside a multiply step")
	`KRE_ASSERT_NOW(a_div_done_owned, clk, arst_n, div_done, state_q == ST_DR_WAIT || state_q == ST_DG_WAIT, "divider finished outside a divide step")

endmodule
